// ===== rtl/core/cartesian_to_spherical_core_macros.svh =====
// Assertion macros shared by the cartesian-to-spherical RTL.
`ifndef CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C2S_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C2S_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/c2s_pkg.sv =====
// Shared constants, types and the gain constant function of the converter.
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

  // Fraction bits added below the input LSB inside the datapath.
  localparam int unsigned GUARD_BITS = 8;
  // Number of tabulated arctangent entries.
  localparam int unsigned ATAN_ENTRIES = 24;

  typedef logic [31:0] turn_t;

  localparam turn_t HALF_TURN = 32'h8000_0000;
  // Start of the lower quarter, where a small negative polar residue lands.
  localparam turn_t PSI_WRAP  = 32'hC000_0000;

  // atan(2^-i) as an unsigned fraction of a full turn.
  localparam turn_t ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Floor quotient by shift and subtract. Elaboration only.
  function automatic logic [63:0] div_floor_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Inverse CORDIC gain for n stages as unsigned Q31: floor of the square
  // root of prod 1/(1+4^-i) held in Q62. Elaboration only.
  function automatic turn_t gain_inv_q31(int unsigned n);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] bm;
    p  = 64'd1 << 62;
    r  = '0;
    bm = 64'd1 << 62;
    for (int i = 0; i < ATAN_ENTRIES; i++) begin
      if (i < n) begin
        p = p - div_floor_u64(p, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    // bitwise integer square root
    for (int k = 0; k < 32; k++) begin
      if (bm > p) begin
        bm = bm >> 2;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (bm != 0) begin
        if (p >= r + bm) begin
          p = p - (r + bm);
          r = (r >> 1) + bm;
        end else begin
          r = r >> 1;
        end
        bm = bm >> 2;
      end
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/c2s_if.sv =====
// Stream interfaces: cartesian request channel and spherical result channel.
`timescale 1ns / 1ps
`default_nettype none

interface c2s_cart_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;
  logic signed [COORD_WIDTH-1:0] z;

  modport source (output valid, output x, output y, output z, input ready);
  modport sink   (input valid, input x, input y, input z, output ready);
endinterface

interface c2s_sph_if #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] theta;
  logic [ANGLE_WIDTH-1:0] psi;
  logic [COORD_WIDTH-1:0] radius;
  logic                   zero_vector;

  modport source (output valid, output theta, output psi, output radius,
                  output zero_vector, input ready);
  modport sink   (input valid, input theta, input psi, input radius,
                  input zero_vector, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cartesian_to_spherical_core.sv =====
// Top level: cartesian to spherical converter built from two CORDIC cell chains.
//
// Usage: points enter on cart_i (x, y, z, signed, common scale) and results
// leave on sph_o (theta, psi, radius, zero_vector) with valid/ready handshakes;
// a request or result moves at a clock edge where valid and ready are high.
// Throughput: one point per clock while the receiver does not stall. From
// acceptance to result valid a point passes the input pre-rotation, the
// azimuth cell chain, a registered gain multiply, the polar pre-rotation, the
// polar cell chain, a second gain multiply and the output register.
// Every cell is a pipeline slot of its own; ready runs back along the chain
// so bubbles close up, and new points are taken while a result still waits.
// When the receiver stalls, the chain fills and cart_i.ready drops once no
// slot is free; results are held and delivered in order, none dropped.
// Reset (rst_ni low, asynchronous) empties all slots; no clearing pass is
// needed and the block takes points right after reset is released.
// All-zero input gives zero angles and radius with zero_vector set.
`timescale 1ns / 1ps
`default_nettype none

`include "cartesian_to_spherical_core_macros.svh"

module cartesian_to_spherical_core #(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c2s_cart_if.sink   cart_i,
  c2s_sph_if.source  sph_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AW   = ANGLE_WIDTH;
  localparam int unsigned GB   = c2s_pkg::GUARD_BITS;
  localparam int unsigned EXT  = 3;
  localparam int unsigned W    = CW + GB + EXT;
  localparam int unsigned DW   = W - 1;
  localparam int unsigned NC   = (CORDIC_STAGES < c2s_pkg::ATAN_ENTRIES) ?
                                 CORDIC_STAGES : c2s_pkg::ATAN_ENTRIES;
  localparam int unsigned SH   = 32 - AW;
  localparam logic [31:0] KINV = c2s_pkg::gain_inv_q31(NC);
  localparam int unsigned SB1  = CW + 2;
  localparam int unsigned SG1  = AW + CW + 1;
  localparam int unsigned SB2  = AW + 1;
  localparam int unsigned SG2  = 2 * AW + 1;
  localparam c2s_pkg::turn_t ANG_RND = c2s_pkg::turn_t'(1) << (SH - 1);
  localparam logic [DW:0] RHO_RND = (DW + 1)'(1) << (GB - 1);
  localparam logic [AW-1:0] HALF_ANGLE = AW'(1) << (AW - 1);

  // ---------------------------------------------------------------
  // Input slot: widen, pre-rotate into the right half plane, flag zeros
  // ---------------------------------------------------------------
  logic                s0_vld_q, s0_rdy;
  logic signed [W-1:0] x_w, y_w;
  logic                x_neg, xy_zero, all_zero;

  logic                p1_vld [NC+1];
  logic                p1_rdy [NC+1];
  logic signed [W-1:0] p1_a   [NC+1];
  logic signed [W-1:0] p1_b   [NC+1];
  c2s_pkg::turn_t      p1_ang [NC+1];
  logic [SB1-1:0]      p1_sb  [NC+1];

  assign x_w      = {{EXT{cart_i.x[CW-1]}}, cart_i.x, {GB{1'b0}}};
  assign y_w      = {{EXT{cart_i.y[CW-1]}}, cart_i.y, {GB{1'b0}}};
  assign x_neg    = cart_i.x[CW-1];
  assign xy_zero  = (cart_i.x == '0) && (cart_i.y == '0);
  assign all_zero = xy_zero && (cart_i.z == '0);

  assign s0_rdy       = !s0_vld_q || p1_rdy[0];
  assign cart_i.ready = s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_q <= cart_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cart_i.valid && s0_rdy) begin
      p1_a[0]   <= x_neg ? -x_w : x_w;
      p1_b[0]   <= x_neg ? -y_w : y_w;
      p1_ang[0] <= x_neg ? c2s_pkg::HALF_TURN : '0;
      p1_sb[0]  <= {cart_i.z, all_zero, xy_zero};
    end
  end

  assign p1_vld[0] = s0_vld_q;

  // ---------------------------------------------------------------
  // Azimuth chain: vectors (x, y)
  // ---------------------------------------------------------------
  for (genvar i = 0; i < NC; i++) begin : g_pass1
    c2s_cordic_cell #(
      .W     (W),
      .STAGE (i),
      .SBW   (SB1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p1_vld[i]),
      .ready_o (p1_rdy[i]),
      .a_i     (p1_a[i]),
      .b_i     (p1_b[i]),
      .ang_i   (p1_ang[i]),
      .sb_i    (p1_sb[i]),
      .valid_o (p1_vld[i+1]),
      .ready_i (p1_rdy[i+1]),
      .a_o     (p1_a[i+1]),
      .b_o     (p1_b[i+1]),
      .ang_o   (p1_ang[i+1]),
      .sb_o    (p1_sb[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Planar length r: gain compensation, theta rounded on the way
  // ---------------------------------------------------------------
  c2s_pkg::turn_t th_sum;
  logic [AW-1:0]  theta_r;
  logic [DW-1:0]  g1_a;
  logic           g1_vld, s2_rdy;
  logic [DW-1:0]  g1_r;
  logic [SG1-1:0] g1_sb;

  assign th_sum  = p1_ang[NC] + ANG_RND;
  assign theta_r = p1_sb[NC][0] ? '0 : th_sum[31:SH];
  assign g1_a    = p1_a[NC][W-1] ? '0 : p1_a[NC][DW-1:0];

  c2s_gain #(
    .DW   (DW),
    .SBW  (SG1),
    .KINV (KINV)
  ) u_gain_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_vld[NC]),
    .ready_o (p1_rdy[NC]),
    .a_i     (g1_a),
    .sb_i    ({theta_r, p1_sb[NC][SB1-1:1]}),
    .valid_o (g1_vld),
    .ready_i (s2_rdy),
    .res_o   (g1_r),
    .sb_o    (g1_sb)
  );

  // ---------------------------------------------------------------
  // Polar pre-rotation: vector (z, r), flip into the right half plane
  // ---------------------------------------------------------------
  logic                s2_vld_q;
  logic signed [W-1:0] z_w, r_w;
  logic                z_neg;

  logic                p2_vld [NC+1];
  logic                p2_rdy [NC+1];
  logic signed [W-1:0] p2_a   [NC+1];
  logic signed [W-1:0] p2_b   [NC+1];
  c2s_pkg::turn_t      p2_ang [NC+1];
  logic [SB2-1:0]      p2_sb  [NC+1];

  assign z_w    = {{EXT{g1_sb[CW]}}, g1_sb[CW:1], {GB{1'b0}}};
  assign r_w    = {1'b0, g1_r};
  assign z_neg  = g1_sb[CW];
  assign s2_rdy = !s2_vld_q || p2_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= g1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g1_vld && s2_rdy) begin
      p2_a[0]   <= z_neg ? -z_w : z_w;
      p2_b[0]   <= z_neg ? -r_w : r_w;
      p2_ang[0] <= z_neg ? c2s_pkg::HALF_TURN : '0;
      p2_sb[0]  <= {g1_sb[SG1-1:CW+1], g1_sb[0]};
    end
  end

  assign p2_vld[0] = s2_vld_q;

  // ---------------------------------------------------------------
  // Polar chain
  // ---------------------------------------------------------------
  for (genvar i = 0; i < NC; i++) begin : g_pass2
    c2s_cordic_cell #(
      .W     (W),
      .STAGE (i),
      .SBW   (SB2)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p2_vld[i]),
      .ready_o (p2_rdy[i]),
      .a_i     (p2_a[i]),
      .b_i     (p2_b[i]),
      .ang_i   (p2_ang[i]),
      .sb_i    (p2_sb[i]),
      .valid_o (p2_vld[i+1]),
      .ready_i (p2_rdy[i+1]),
      .a_o     (p2_a[i+1]),
      .b_o     (p2_b[i+1]),
      .ang_o   (p2_ang[i+1]),
      .sb_o    (p2_sb[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Radius gain compensation, psi clamped to [0, pi] and rounded
  // ---------------------------------------------------------------
  c2s_pkg::turn_t ps_c, ps_sum;
  logic [AW-1:0]  psi_r;
  logic [DW-1:0]  g2_a;
  logic           g2_vld, out_rdy;
  logic [DW-1:0]  g2_r;
  logic [SG2-1:0] g2_sb;

  always_comb begin
    priority if (p2_ang[NC] >= c2s_pkg::PSI_WRAP) begin
      ps_c = '0;
    end else if (p2_ang[NC] > c2s_pkg::HALF_TURN) begin
      ps_c = c2s_pkg::HALF_TURN;
    end else begin
      ps_c = p2_ang[NC];
    end
  end

  assign ps_sum = ps_c + ANG_RND;
  assign psi_r  = ps_sum[31:SH];
  assign g2_a   = p2_a[NC][W-1] ? '0 : p2_a[NC][DW-1:0];

  c2s_gain #(
    .DW   (DW),
    .SBW  (SG2),
    .KINV (KINV)
  ) u_gain_rho (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_vld[NC]),
    .ready_o (p2_rdy[NC]),
    .a_i     (g2_a),
    .sb_i    ({p2_sb[NC][SB2-1:1], psi_r, p2_sb[NC][0]}),
    .valid_o (g2_vld),
    .ready_i (out_rdy),
    .res_o   (g2_r),
    .sb_o    (g2_sb)
  );

  // ---------------------------------------------------------------
  // Output register: drop guard bits, saturate, zero-vector override
  // ---------------------------------------------------------------
  logic            out_vld_q;
  logic [AW-1:0]   out_theta_q, out_psi_q;
  logic [CW-1:0]   out_radius_q;
  logic            out_zero_q;
  logic [DW:0]     rho_sum;
  logic [DW-GB:0]  rho_sh;
  logic [CW-1:0]   rho_sat;

  assign rho_sum = {1'b0, g2_r} + RHO_RND;
  assign rho_sh  = rho_sum[DW:GB];
  assign rho_sat = (rho_sh[DW-GB:CW] != '0) ? '1 : rho_sh[CW-1:0];
  assign out_rdy = !out_vld_q || sph_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= g2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g2_vld && out_rdy) begin
      out_zero_q <= g2_sb[0];
      if (g2_sb[0]) begin
        out_theta_q  <= '0;
        out_psi_q    <= '0;
        out_radius_q <= '0;
      end else begin
        out_theta_q  <= g2_sb[SG2-1:AW+1];
        out_psi_q    <= g2_sb[AW:1];
        out_radius_q <= rho_sat;
      end
    end
  end

  assign sph_o.valid       = out_vld_q;
  assign sph_o.theta       = out_theta_q;
  assign sph_o.psi         = out_psi_q;
  assign sph_o.radius      = out_radius_q;
  assign sph_o.zero_vector = out_zero_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `C2S_ASSERT_IMP(a_ready_when_out_free, !out_vld_q, cart_i.ready,
                  "input not ready although the output slot is empty")
  `C2S_ASSERT_IMP(a_zero_vector_result, out_vld_q && out_zero_q,
                  (out_theta_q == '0) && (out_psi_q == '0) && (out_radius_q == '0),
                  "zero vector result with nonzero angle or radius")
  `C2S_ASSERT_IMP(a_psi_in_range, out_vld_q, out_psi_q <= HALF_ANGLE,
                  "polar angle above a half turn")
  `C2S_ASSERT_NXT(a_output_loads, g2_vld && out_rdy, out_vld_q,
                  "finished result not loaded into the output register")

endmodule

`default_nettype wire

// ===== rtl/core/c2s_cordic_cell.sv =====
// One registered CORDIC vectoring micro-rotation with its own pipeline slot.
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_cell #(
  parameter int unsigned W     = 35,
  parameter int unsigned STAGE = 0,
  parameter int unsigned SBW   = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output      logic                ready_o,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  input  wire c2s_pkg::turn_t      ang_i,
  input  wire logic [SBW-1:0]      sb_i,
  output      logic                valid_o,
  input  wire logic                ready_i,
  output      logic signed [W-1:0] a_o,
  output      logic signed [W-1:0] b_o,
  output      c2s_pkg::turn_t      ang_o,
  output      logic [SBW-1:0]      sb_o
);

  logic                valid_q;
  logic signed [W-1:0] a_q, a_d;
  logic signed [W-1:0] b_q, b_d;
  c2s_pkg::turn_t      ang_q, ang_d;
  logic [SBW-1:0]      sb_q;
  logic signed [W-1:0] a_sh, b_sh;

  // slot frees when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  // rotate toward the x axis, direction from the sign of b
  always_comb begin
    a_sh = a_i >>> STAGE;
    b_sh = b_i >>> STAGE;
    if (!b_i[W-1]) begin
      a_d   = a_i + b_sh;
      b_d   = b_i - a_sh;
      ang_d = ang_i + c2s_pkg::ATAN_TURNS[STAGE];
    end else begin
      a_d   = a_i - b_sh;
      b_d   = b_i + a_sh;
      ang_d = ang_i - c2s_pkg::ATAN_TURNS[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_q   <= a_d;
      b_q   <= b_d;
      ang_q <= ang_d;
      sb_q  <= sb_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign ang_o   = ang_q;
  assign sb_o    = sb_q;

endmodule

`default_nettype wire

// ===== rtl/core/c2s_gain.sv =====
// Two-stage multiply by the inverse CORDIC gain (Q31), rounded half up.
`timescale 1ns / 1ps
`default_nettype none

module c2s_gain #(
  parameter int unsigned DW          = 34,
  parameter int unsigned SBW         = 1,
  parameter logic [31:0] KINV        = 32'd1304065748
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire logic [DW-1:0]  a_i,
  input  wire logic [SBW-1:0] sb_i,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      logic [DW-1:0]  res_o,
  output      logic [SBW-1:0] sb_o
);

  localparam int unsigned PW = DW + 16;
  localparam logic [PW:0] RND = (PW + 1)'(1) << 14;

  logic           vld_a_q, vld_b_q;
  logic           rdy_b;
  logic [PW-1:0]  a_ext;
  logic [PW-1:0]  hi_q, lo_q;
  logic [SBW-1:0] sb_a_q, sb_b_q;
  logic [PW:0]    sum;
  logic [DW-1:0]  res_q;

  assign rdy_b   = !vld_b_q || ready_i;
  assign ready_o = !vld_a_q || rdy_b;
  assign a_ext   = PW'(a_i);

  // sum of the two partial products, the low one truncated by 16 first
  assign sum = {1'b0, hi_q} + (PW + 1)'(lo_q >> 16) + RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (ready_o) begin
        vld_a_q <= valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  // stage A: split multiply on the upper and lower gain halves
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hi_q   <= a_ext * PW'(KINV[31:16]);
      lo_q   <= a_ext * PW'(KINV[15:0]);
      sb_a_q <= sb_i;
    end
  end

  // stage B: combine and drop the Q31 fraction
  always_ff @(posedge clk_i) begin
    if (vld_a_q && rdy_b) begin
      res_q  <= sum[DW+14:15];
      sb_b_q <= sb_a_q;
    end
  end

  assign valid_o = vld_b_q;
  assign res_o   = res_q;
  assign sb_o    = sb_b_q;

endmodule

`default_nettype wire

// ===== dv/tb_cartesian_to_spherical_core.sv =====
// Self-checking testbench for the cartesian to spherical CORDIC converter.
`timescale 1ns / 1ps

module tb_cartesian_to_spherical_core;

  localparam int COORD_W   = 24;
  localparam int ANGLE_W   = 16;
  localparam int STAGES    = 16;
  localparam int GUARD     = 8;
  localparam int ATAN_ROWS = 24;
  // acceptance to result; the tail wait adds a margin on top
  localparam int PIPE_LATENCY = 2 * STAGES + 7;

  localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
  localparam logic [31:0] TURN_3QTR  = 32'hC000_0000;
  localparam logic [31:0] ANGLE_HALF_LSB = 32'd1 << (32 - ANGLE_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam longint unsigned RADIUS_MAX = (64'd1 << COORD_W) - 1;

  typedef struct packed {
    logic [ANGLE_W-1:0] theta;
    logic [ANGLE_W-1:0] psi;
    logic [COORD_W-1:0] radius;
    logic               zero_vector;
  } sph_point_t;

  typedef enum int unsigned {FULL_RANGE, NEAR_ORIGIN, EDGE_VALUE} coord_flavor_e;

  // atan(2^-i) in 32-bit fractions of a full turn
  localparam logic [31:0] ATAN_STEP [ATAN_ROWS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  logic clk = 1'b0;
  logic rst_n;

  c2s_cart_if #(.COORD_WIDTH(COORD_W)) cart_if ();
  c2s_sph_if #(.COORD_WIDTH(COORD_W), .ANGLE_WIDTH(ANGLE_W)) sph_if ();

  cartesian_to_spherical_core #(
    .COORD_WIDTH  (COORD_W),
    .ANGLE_WIDTH  (ANGLE_W),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cart_i(cart_if),
    .sph_o (sph_if)
  );

  sph_point_t       pending_points[$];
  int               mismatch_count = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      sink_stall_pct = 0;
  int unsigned      sink_hold_cycles = 0;
  longint unsigned  gain_inv;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint unsigned isqrt_floor(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // 1/K for the stage count, unsigned Q31
  function automatic longint unsigned inverse_gain_q31();
    longint unsigned prod;
    int              n;
    prod = 64'd1 << 62;
    n    = (STAGES < ATAN_ROWS) ? STAGES : ATAN_ROWS;
    for (int i = 0; i < n; i++) begin
      prod = prod - prod / ((64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt_floor(prod);
  endfunction

  // round(mag * k / 2^31), split to stay inside 64 bits
  function automatic longint unsigned gain_compensate(input longint unsigned mag,
                                                      input longint unsigned k);
    longint unsigned hi;
    longint unsigned lo;
    hi = mag * (k >> 16);
    lo = mag * (k & 64'hFFFF);
    return (hi + (lo >> 16) + (64'd1 << 14)) >> 15;
  endfunction

  // Rotates (a, b) onto the positive a axis; returns the angle in turns.
  function automatic logic [31:0] cordic_vectoring_pass(inout longint a, inout longint b);
    longint      prev_a;
    logic [31:0] ang;
    int          n;
    ang = '0;
    n   = (STAGES < ATAN_ROWS) ? STAGES : ATAN_ROWS;
    if (a < 0) begin
      a   = -a;
      b   = -b;
      ang = TURN_HALF;
    end
    for (int i = 0; i < n; i++) begin
      prev_a = a;
      if (b >= 0) begin
        a   = a + (b >>> i);
        b   = b - (prev_a >>> i);
        ang = ang + ATAN_STEP[i];
      end else begin
        a   = a - (b >>> i);
        b   = b + (prev_a >>> i);
        ang = ang - ATAN_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic sph_point_t predict_spherical(input coord_t px, input coord_t py,
                                                   input coord_t pz);
    sph_point_t      res;
    longint          a;
    longint          b;
    longint unsigned planar;
    longint unsigned rho;
    logic [31:0]     az_turns;
    logic [31:0]     polar_turns;
    logic [31:0]     rounded;
    res = '0;
    if (px == 0 && py == 0 && pz == 0) begin
      res.zero_vector = 1'b1;
      return res;
    end
    // azimuth pass on (x, y)
    a = longint'(px) * (64'sd1 <<< GUARD);
    b = longint'(py) * (64'sd1 <<< GUARD);
    az_turns = cordic_vectoring_pass(a, b);
    if (px == 0 && py == 0) az_turns = '0;
    planar = gain_compensate((a < 0) ? 64'd0 : longint'(a), gain_inv);
    // polar pass on (z, r)
    a = longint'(pz) * (64'sd1 <<< GUARD);
    b = longint'(planar);
    polar_turns = cordic_vectoring_pass(a, b);
    // clamp small residues outside [0, pi]
    if (polar_turns >= TURN_3QTR) polar_turns = '0;
    else if (polar_turns > TURN_HALF) polar_turns = TURN_HALF;
    rho = gain_compensate((a < 0) ? 64'd0 : longint'(a), gain_inv);
    rho = (rho + (64'd1 << (GUARD - 1))) >> GUARD;
    if (rho > RADIUS_MAX) rho = RADIUS_MAX;
    rounded    = az_turns + ANGLE_HALF_LSB;
    res.theta  = rounded[31 -: ANGLE_W];
    rounded    = polar_turns + ANGLE_HALF_LSB;
    res.psi    = rounded[31 -: ANGLE_W];
    res.radius = rho[COORD_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offers one point, idling at random first; predicts on acceptance.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cart_if.valid <= 1'b0;
      cart_if.x     <= coord_t'($urandom);
      cart_if.y     <= coord_t'($urandom);
      cart_if.z     <= coord_t'($urandom);
      @(posedge clk);
    end
    cart_if.valid <= 1'b1;
    cart_if.x     <= px;
    cart_if.y     <= py;
    cart_if.z     <= pz;
    @(posedge clk);
    while (!cart_if.ready) @(posedge clk);
    pending_points.push_back(predict_spherical(px, py, pz));
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_for_results();
    cart_if.valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  function automatic coord_t random_coord(input coord_flavor_e flavor);
    coord_t v;
    case (flavor)
      FULL_RANGE: v = coord_t'($urandom);
      NEAR_ORIGIN: begin
        v = coord_t'($urandom_range(0, 128));
        v = v - coord_t'(64);
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = COORD_MAX;
          1:       v = COORD_MIN;
          2:       v = '0;
          3:       v = coord_t'(1);
          default: v = coord_t'(-1);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_point();
    coord_t      px;
    coord_t      py;
    coord_t      pz;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    px = random_coord(FULL_RANGE);
    py = random_coord(FULL_RANGE);
    pz = random_coord(FULL_RANGE);
    if (roll < 2) begin
      px = '0; py = '0; pz = '0;
    end else if (roll < 7) begin
      // on the z axis
      px = '0; py = '0;
      pz = random_coord(coord_flavor_e'($urandom_range(0, 2)));
    end else if (roll < 12) begin
      pz = '0;
    end else if (roll < 25) begin
      px = random_coord(coord_flavor_e'($urandom_range(0, 2)));
      py = random_coord(coord_flavor_e'($urandom_range(0, 2)));
      pz = random_coord(coord_flavor_e'($urandom_range(0, 2)));
    end
    send_point(px, py, pz);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, long hold-off, in-order check
  // ---------------------------------------------------------------------

  task automatic check_result(input sph_point_t got);
    sph_point_t want;
    if (pending_points.size() == 0) begin
      $display("%0t unexpected result: expected none, got theta %0d psi %0d radius %0d zero %0b",
               $time, got.theta, got.psi, got.radius, got.zero_vector);
      mismatch_count++;
      return;
    end
    want = pending_points.pop_front();
    if (got.theta !== want.theta) begin
      $display("%0t theta mismatch: expected %0d, got %0d", $time, want.theta, got.theta);
      mismatch_count++;
    end
    if (got.psi !== want.psi) begin
      $display("%0t psi mismatch: expected %0d, got %0d", $time, want.psi, got.psi);
      mismatch_count++;
    end
    if (got.radius !== want.radius) begin
      $display("%0t radius mismatch: expected %0d, got %0d", $time, want.radius, got.radius);
      mismatch_count++;
    end
    if (got.zero_vector !== want.zero_vector) begin
      $display("%0t zero_vector mismatch: expected %0b, got %0b", $time,
               want.zero_vector, got.zero_vector);
      mismatch_count++;
    end
  endtask

  initial begin
    sph_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && sph_if.valid && sph_if.ready) begin
        check_result('{theta: sph_if.theta, psi: sph_if.psi, radius: sph_if.radius,
                       zero_vector: sph_if.zero_vector});
      end
      if (sink_hold_cycles > 0) begin
        sph_if.ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        sph_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Extremes, axes, origin, theta wrap near a full turn, psi near 0 and pi.
  task automatic test_directed_points();
    send_point('0, '0, '0);
    send_point(COORD_MAX, '0, '0);
    send_point(COORD_MIN, '0, '0);
    send_point('0, COORD_MAX, '0);
    send_point('0, COORD_MIN, '0);
    send_point('0, '0, COORD_MAX);
    send_point('0, '0, COORD_MIN);
    send_point('0, '0, coord_t'(1));
    send_point('0, '0, coord_t'(-1));
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(coord_t'(1), '0, '0);
    send_point(coord_t'(-1), '0, '0);
    send_point('0, coord_t'(-1), '0);
    send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_point(coord_t'(1), coord_t'(1), coord_t'(1));
    send_point(COORD_MAX, COORD_MIN, '0);
    send_point(COORD_MAX, coord_t'(-1), '0);
    send_point(COORD_MIN, coord_t'(1), '0);
    send_point(COORD_MIN, coord_t'(-1), '0);
    send_point(coord_t'(1), '0, COORD_MIN);
    send_point(coord_t'(1), '0, COORD_MAX);
    send_point('0, coord_t'(1), coord_t'(-1));
    send_point(coord_t'(5), coord_t'(-3), coord_t'(7));
    wait_for_results();
  endtask

  task automatic test_random_points(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    repeat (count) send_random_point();
    wait_for_results();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall requests.
  task automatic test_output_stall();
    sender_idle_pct  = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 300;
    repeat (150) send_random_point();
    wait_for_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    cart_if.valid = 1'b0;
    cart_if.x     = '0;
    cart_if.y     = '0;
    cart_if.z     = '0;
    gain_inv      = inverse_gain_q31();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 8;
    sink_stall_pct  = 63;
    test_directed_points();
    test_random_points(250, 8, 63);
    test_random_points(250, 63, 8);
    test_random_points(250, 0, 0);
    test_output_stall();

    // catch any stray result after the last expected one
    sink_stall_pct = 0;
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_cartesian_to_spherical_core: clean");
    end else begin
      $display("tb_cartesian_to_spherical_core: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_cartesian_to_spherical_core: errors");
    $finish;
  end

endmodule
